// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the framer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset
`define PSF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset
`define PSF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/psf_pkg.sv -----
// Types, constants and register codes of the preamble/sync/length framer.
package psf_pkg;

    localparam int MAX_PREAMBLE_DEF   = 32;
    localparam int MAX_SYNC_BYTES_DEF = 8;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 16;
    localparam int PCOUNT_W    = 6;
    localparam int SYNC_W      = 64;
    localparam int SLEN_W      = 4;
    localparam int SYNC_IDX_W  = 3;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 8;

    // Register reset values
    localparam logic [BYTE_W-1:0]   PREAMBLE_BYTE_RST  = 8'hAA;
    localparam logic [PCOUNT_W-1:0] PREAMBLE_COUNT_RST = 6'd8;
    localparam logic [SYNC_W-1:0]   SYNC_PATTERN_RST   = 64'd0;
    localparam logic [SLEN_W-1:0]   SYNC_LEN_RST       = 4'd0;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PREAMBLE_BYTE  = 2'd0,
        REG_PREAMBLE_COUNT = 2'd1,
        REG_SYNC_PATTERN   = 2'd2,
        REG_SYNC_LEN       = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   preamble_byte;
        logic [PCOUNT_W-1:0] preamble_count;
        logic [SYNC_W-1:0]   sync_pattern;
        logic [SLEN_W-1:0]   sync_len;
    } cfg_t;

    // One input request as held in front of the emitter
    typedef struct packed {
        logic [LEN_W-1:0]  packet_len;
        logic              start_of_packet;
        logic [BYTE_W-1:0] data_byte;
    } in_item_t;

    // One frame byte on its way out
    typedef struct packed {
        logic              frame_last;
        logic              run_last;
        logic [BYTE_W-1:0] out_byte;
    } out_item_t;

    // Emitter status seen by the top level
    typedef struct packed {
        logic             hdr_active;
        logic [LEN_W-1:0] remaining;
    } emit_status_t;

endpackage

// ----- rtl/core/psf_skid.sv -----
// Two-entry skid buffer with registered ready on the upstream side.
module psf_skid #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             main_v_reg;
    logic [WIDTH-1:0] main_d_reg;
    logic             skid_v_reg;
    logic [WIDTH-1:0] skid_d_reg;

    assign in_ready  = !skid_v_reg;
    assign out_valid = main_v_reg;
    assign out_data  = main_d_reg;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (out_ready || !main_v_reg) begin
            if (skid_v_reg) begin
                main_v_reg <= 1'b1;
                skid_v_reg <= 1'b0;
            end else begin
                main_v_reg <= in_valid;
            end
        end else if (in_valid && !skid_v_reg) begin
            skid_v_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (out_ready || !main_v_reg) begin
            main_d_reg <= skid_v_reg ? skid_d_reg : in_data;
        end else if (in_valid && !skid_v_reg) begin
            skid_d_reg <= in_data;
        end
    end

endmodule

// ----- rtl/core/psf_cfg_regs.sv -----
// Configuration register file of the framer.
module psf_cfg_regs
    import psf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    assign cfg = cfg_reg;

    // Register writes, decoded by index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.preamble_byte  <= PREAMBLE_BYTE_RST;
            cfg_reg.preamble_count <= PREAMBLE_COUNT_RST;
            cfg_reg.sync_pattern   <= SYNC_PATTERN_RST;
            cfg_reg.sync_len       <= SYNC_LEN_RST;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_PREAMBLE_BYTE:  cfg_reg.preamble_byte  <= cfg_wr_data[BYTE_W-1:0];
                REG_PREAMBLE_COUNT: cfg_reg.preamble_count <= cfg_wr_data[PCOUNT_W-1:0];
                REG_SYNC_PATTERN:   cfg_reg.sync_pattern   <= cfg_wr_data[SYNC_W-1:0];
                REG_SYNC_LEN:       cfg_reg.sync_len       <= cfg_wr_data[SLEN_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/core/psf_emitter.sv -----
// Frame byte emitter: header sequencer and payload pass-through.
module psf_emitter
    import psf_pkg::*;
#(
    parameter int MAX_PREAMBLE   = MAX_PREAMBLE_DEF,
    parameter int MAX_SYNC_BYTES = MAX_SYNC_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  cfg_t         cfg,
    input  logic         held_valid,
    input  in_item_t     held,
    output logic         held_consume,
    output logic         emit_valid,
    input  logic         emit_ready,
    output out_item_t    emit,
    output emit_status_t status
);

    localparam int POS_W = $clog2(MAX_PREAMBLE + MAX_SYNC_BYTES + 3);

    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic [LEN_W-1:0]      remaining_reg;
    logic [LEN_W-1:0]      remaining_next;
    logic [7:0]            np8;
    logic [SLEN_W-1:0]     ns4;
    logic [POS_W-1:0]      np;
    logic [POS_W-1:0]      ns;
    logic [POS_W-1:0]      hdr_end;
    logic [POS_W-1:0]      sync_off;
    logic [SYNC_IDX_W-1:0] sync_idx;
    logic                  fire;

    // Clamp counts to the supported maximum
    assign np8 = ({2'b00, cfg.preamble_count} > 8'(MAX_PREAMBLE)) ?
                 8'(MAX_PREAMBLE) : {2'b00, cfg.preamble_count};
    assign ns4 = (cfg.sync_len > SLEN_W'(MAX_SYNC_BYTES)) ?
                 SLEN_W'(MAX_SYNC_BYTES) : cfg.sync_len;
    assign np  = POS_W'(np8);
    assign ns  = POS_W'(ns4);

    assign hdr_end  = np + ns;
    assign sync_off = pos_reg - np;
    assign sync_idx = SYNC_IDX_W'(ns - POS_W'(1) - sync_off);

    // Byte select for the current position
    always_comb begin
        emit.out_byte   = held.data_byte;
        emit.run_last   = 1'b1;
        emit.frame_last = (remaining_reg == LEN_W'(1));
        if (held.start_of_packet) begin
            emit.run_last   = 1'b0;
            emit.frame_last = 1'b0;
            if (pos_reg < np) begin
                emit.out_byte = cfg.preamble_byte;
            end else if (pos_reg < hdr_end) begin
                emit.out_byte = cfg.sync_pattern[{sync_idx, 3'b000} +: BYTE_W];
            end else if (pos_reg == hdr_end) begin
                emit.out_byte = held.packet_len[LEN_W-1:BYTE_W];
            end else if (pos_reg == hdr_end + POS_W'(1)) begin
                emit.out_byte   = held.packet_len[BYTE_W-1:0];
                emit.run_last   = (held.packet_len == '0);
                emit.frame_last = (held.packet_len == '0);
            end else begin
                emit.out_byte   = held.data_byte;
                emit.run_last   = 1'b1;
                emit.frame_last = (held.packet_len == LEN_W'(1));
            end
        end
    end

    // Handshake: stray bytes are consumed with no output
    assign emit_valid   = held_valid && (held.start_of_packet || remaining_reg != '0);
    assign fire         = emit_valid && emit_ready;
    assign held_consume = held_valid && (!emit_valid || (fire && emit.run_last));

    // Next position and payload count
    always_comb begin
        pos_next       = pos_reg;
        remaining_next = remaining_reg;
        if (fire) begin
            pos_next = emit.run_last ? '0 : pos_reg + POS_W'(1);
            if (emit.run_last) begin
                if (held.start_of_packet) begin
                    remaining_next = (held.packet_len == '0) ? '0 :
                                     held.packet_len - LEN_W'(1);
                end else begin
                    remaining_next = remaining_reg - LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            remaining_reg <= '0;
        end else begin
            pos_reg       <= pos_next;
            remaining_reg <= remaining_next;
        end
    end

    assign status.hdr_active = (pos_reg != '0);
    assign status.remaining  = remaining_reg;

endmodule

// ----- rtl/core/preamble_sync_length_framer_unit.sv -----
// Top level of the preamble/sync/length-prefixed transmit framer.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata {packet_len, data_byte}, tuser start, tlast end
//  m_*       out  m_tvalid/m_tready  tdata out_byte, tuser run_last, tlast frame_last
//  cfg_*     in   cfg_wr_en          cfg_addr index, cfg_wr_data value
//
// Payload requests pass at one per cycle unless m_tready stalls, through the input and
// result register stages. A start request holds the emitter for np + ns + 2 bytes (one
// more with a nonzero length), np and ns being the clamped preamble and sync byte counts.
// Skid buffers on both sides register s_tready and decouple m_tready stalls.
// Reset is synchronous, active low, and loads the register defaults.
`include "assert_macros.svh"

module preamble_sync_length_framer_unit
    import psf_pkg::*;
#(
    parameter int MAX_PREAMBLE   = MAX_PREAMBLE_DEF,
    parameter int MAX_SYNC_BYTES = MAX_SYNC_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // data_byte[7:0], packet_len[23:8]
    input  logic                  s_tuser,   // start_of_packet
    input  logic                  s_tlast,   // end_of_packet
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // out_byte[7:0]
    output logic                  m_tuser,   // run_last
    output logic                  m_tlast,   // frame_last
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    cfg_t         cfg;
    in_item_t     in_item;
    in_item_t     held;
    logic         held_valid;
    logic         held_consume;
    out_item_t    emit;
    logic         emit_valid;
    logic         emit_ready;
    out_item_t    out_item;
    emit_status_t status;
    logic         unused_tlast;

    // end_of_packet carries no meaning here; frame end follows the length
    assign unused_tlast = s_tlast;

    assign in_item.packet_len      = s_tdata[S_TDATA_W-1:BYTE_W];
    assign in_item.start_of_packet = s_tuser;
    assign in_item.data_byte       = s_tdata[BYTE_W-1:0];

    psf_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // Input register stage
    psf_skid #(.WIDTH($bits(in_item_t))) u_in_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (in_item),
        .out_valid (held_valid),
        .out_ready (held_consume),
        .out_data  (held)
    );

    psf_emitter #(
        .MAX_PREAMBLE   (MAX_PREAMBLE),
        .MAX_SYNC_BYTES (MAX_SYNC_BYTES)
    ) u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .held_valid   (held_valid),
        .held         (held),
        .held_consume (held_consume),
        .emit_valid   (emit_valid),
        .emit_ready   (emit_ready),
        .emit         (emit),
        .status       (status)
    );

    // Result register stage
    psf_skid #(.WIDTH($bits(out_item_t))) u_out_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (emit_valid),
        .in_ready  (emit_ready),
        .in_data   (emit),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_item)
    );

    assign m_tdata = out_item.out_byte;
    assign m_tuser = out_item.run_last;
    assign m_tlast = out_item.frame_last;

    // Checks
    `PSF_ASSERT_IMP(a_frame_ends_run, m_tvalid && m_tlast, m_tuser,
        "frame_last without run_last")
    `PSF_ASSERT_IMP(a_hdr_on_start, status.hdr_active, held_valid && held.start_of_packet,
        "header sequence running without a start request")
    `PSF_ASSERT_NXT(a_frame_end_count, emit_valid && emit_ready && emit.frame_last,
        status.remaining == '0, "payload count not zero after frame end")

endmodule

// ----- verif/preamble_sync_length_framer_unit_tb.sv -----
// Self-checking testbench for the preamble/sync/length-prefixed transmit framer.
module preamble_sync_length_framer_unit_tb;
    import psf_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 10;
    localparam int SETTLE_CYCLES = 16;     // pipeline and skid buffers drain
    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
    localparam int RUN_LIMIT    = 20 * 600000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;    // data_byte[7:0], packet_len[23:8]
    logic                  s_tuser = 1'b0;  // start_of_packet
    logic                  s_tlast = 1'b0;  // end_of_packet
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // out_byte[7:0]
    logic                  m_tuser;         // run_last
    logic                  m_tlast;         // frame_last
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    preamble_sync_length_framer_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Framer model: register copies and payload countdown
    logic [BYTE_W-1:0]   mdl_pbyte  = PREAMBLE_BYTE_RST;
    logic [PCOUNT_W-1:0] mdl_pcount = PREAMBLE_COUNT_RST;
    logic [SYNC_W-1:0]   mdl_sync   = SYNC_PATTERN_RST;
    logic [SLEN_W-1:0]   mdl_slen   = SYNC_LEN_RST;
    int                  payload_left = 0;
    out_item_t           frame_bytes_q[$];

    int mismatch_count = 0;

    // Sender burst state
    int burst_left = 0;
    int gap_max    = 4;
    bit gaps_on    = 1'b1;

    // Receiver stall controls
    int ready_pct  = 100;
    int hold_reqs  = 0;
    int hold_done  = 0;
    int hold_left  = 0;

    // Expected frame bytes for one accepted request
    function automatic void predict_frame(input logic [BYTE_W-1:0] data, input logic sop,
                                          input logic [LEN_W-1:0] len);
        out_item_t run[$];
        out_item_t b;
        int np;
        int ns;
        np = (mdl_pcount > MAX_PREAMBLE_DEF) ? MAX_PREAMBLE_DEF : int'(mdl_pcount);
        ns = (mdl_slen > MAX_SYNC_BYTES_DEF) ? MAX_SYNC_BYTES_DEF : int'(mdl_slen);
        b = '0;
        if (sop) begin
            for (int i = 0; i < np; i++) begin
                b.out_byte = mdl_pbyte;
                run = {run, b};
            end
            // sync bytes, most significant used byte first
            for (int i = 0; i < ns; i++) begin
                b.out_byte = 8'(mdl_sync >> (8 * (ns - 1 - i)));
                run = {run, b};
            end
            b.out_byte = len[15:8];
            run = {run, b};
            b.out_byte = len[7:0];
            b.frame_last = (len == 0);
            run = {run, b};
            payload_left = int'(len);
            if (payload_left != 0) begin
                payload_left--;
                b.out_byte = data;
                b.frame_last = (payload_left == 0);
                run = {run, b};
            end
        end else if (payload_left != 0) begin
            payload_left--;
            b.out_byte = data;
            b.frame_last = (payload_left == 0);
            run = {run, b};
        end
        if (run.size() > 0)
            run[run.size()-1].run_last = 1'b1;
        foreach (run[i])
            frame_bytes_q = {frame_bytes_q, run[i]};
    endfunction

    // Check every accepted frame byte against the oldest expectation
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_bytes_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: extra byte: expected none, actual %02h/%0b/%0b",
                         $time, m_tdata, m_tuser, m_tlast);
            end else begin
                want = frame_bytes_q.pop_front();
                if (m_tdata !== want.out_byte) begin
                    mismatch_count++;
                    $display("%0t: out_byte mismatch: expected %02h actual %02h",
                             $time, want.out_byte, m_tdata);
                end
                if (m_tuser !== want.run_last) begin
                    mismatch_count++;
                    $display("%0t: run_last mismatch: expected %0b actual %0b",
                             $time, want.run_last, m_tuser);
                end
                if (m_tlast !== want.frame_last) begin
                    mismatch_count++;
                    $display("%0t: frame_last mismatch: expected %0b actual %0b",
                             $time, want.frame_last, m_tlast);
                end
            end
        end
    end

    // Receiver: random stalls, plus a counted hold-off on request
    always @(negedge aclk) begin
        if (hold_reqs != hold_done) begin
            hold_done = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else begin
            m_tready = ($urandom_range(99) < ready_pct);
        end
    end

    // Send one request; called and returns at a falling edge
    task automatic send_item(input logic [BYTE_W-1:0] data, input logic sop,
                             input logic eop, input logic [LEN_W-1:0] len);
        if (burst_left == 0) begin
            if (gaps_on) begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(0, gap_max)) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid = 1'b1;
        s_tdata  = {len, data};
        s_tuser  = sop;
        s_tlast  = eop;
        do @(posedge aclk); while (!s_tready);
        predict_frame(data, sop, len);
        burst_left--;
        @(negedge aclk);
    endtask

    // Start request plus body bytes; end_of_packet marks the announced last byte
    task automatic send_packet(input int len, input int body);
        send_item(8'($urandom_range(0, 255)), 1'b1, len == 1, len[15:0]);
        for (int i = 1; i <= body; i++)
            send_item(8'($urandom_range(0, 255)), 1'b0, i == len - 1,
                      16'($urandom_range(0, 65535)));
    endtask

    // Wait until every expected byte is out and the block is quiet
    task automatic drain();
        s_tvalid = 1'b0;
        burst_left = 0;
        while (frame_bytes_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en   = 1'b1;
        cfg_addr    = idx;
        cfg_wr_data = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_PREAMBLE_BYTE:  mdl_pbyte  = val[BYTE_W-1:0];
            REG_PREAMBLE_COUNT: mdl_pcount = val[PCOUNT_W-1:0];
            REG_SYNC_PATTERN:   mdl_sync   = val;
            REG_SYNC_LEN:       mdl_slen   = val[SLEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] pbyte, input logic [5:0] pcount,
                              input logic [63:0] sword, input logic [3:0] slen);
        write_reg(REG_PREAMBLE_BYTE, CFG_DATA_W'(pbyte));
        write_reg(REG_PREAMBLE_COUNT, CFG_DATA_W'(pcount));
        write_reg(REG_SYNC_PATTERN, sword);
        write_reg(REG_SYNC_LEN, CFG_DATA_W'(slen));
    endtask

    // Reset defaults: stray byte, short packets, zero length
    task automatic test_reset_defaults();
        ready_pct = 100;
        send_item(8'hFF, 1'b0, 1'b1, 16'hFFFF);     // stray, no result
        send_item(8'h00, 1'b1, 1'b1, 16'd1);
        send_item(8'hFF, 1'b1, 1'b0, 16'd0);        // header only, byte dropped
        send_item(8'h5A, 1'b1, 1'b0, 16'd2);
        send_item(8'hFF, 1'b0, 1'b1, 16'd0);
        drain();
    endtask

    // Register extremes, saturation and abandoned packets
    task automatic test_config_extremes();
        ready_pct = 70;
        set_config(8'h00, 6'd0, 64'd0, 4'd0);
        send_item(8'hFF, 1'b1, 1'b0, 16'hFFFF);
        send_item(8'h00, 1'b0, 1'b0, 16'h0000);
        send_item(8'hFF, 1'b0, 1'b1, 16'hFFFF);
        send_item(8'h81, 1'b1, 1'b0, 16'd3);        // start during a packet
        send_item(8'h7E, 1'b0, 1'b0, 16'd0);
        send_item(8'h42, 1'b0, 1'b1, 16'd0);
        send_item(8'h99, 1'b0, 1'b0, 16'd0);        // stray after the end
        drain();
        // counts above the maximum saturate
        set_config(8'hFF, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        send_item(8'hC3, 1'b1, 1'b1, 16'd1);
        drain();
        set_config(8'h55, 6'd32, 64'h0123_4567_89AB_CDEF, 4'd8);
        send_item(8'h3C, 1'b1, 1'b0, 16'd2);
        send_item(8'hA5, 1'b0, 1'b1, 16'd0);
        drain();
        set_config(8'h0F, 6'd1, 64'hFEDC_BA98_7654_3210, 4'd1);
        send_item(8'hE7, 1'b1, 1'b1, 16'd0);
        send_item(8'h18, 1'b1, 1'b1, 16'd1);
        drain();
    endtask

    // Random configurations with mostly well-formed packets
    task automatic test_random_traffic();
        int sent;
        int len;
        int pick;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_config(8'($urandom_range(0, 255)), 6'd0, {$urandom, $urandom}, 4'd8);
                1: set_config(8'($urandom_range(0, 255)), 6'd63, {$urandom, $urandom}, 4'd0);
                default: set_config(8'($urandom_range(0, 255)), 6'($urandom_range(0, 12)),
                                    {$urandom, $urandom}, 4'($urandom_range(0, 15)));
            endcase
            ready_pct = (phase == 3) ? 100 : int'($urandom_range(30, 90));
            gaps_on   = (phase != 3);
            sent = 0;
            while (sent < 60) begin
                pick = int'($urandom_range(0, 99));
                if (pick < 72) begin
                    len = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 16));
                    send_packet(len, (len == 0) ? 0 : len - 1);
                    sent += (len == 0) ? 1 : len;
                end else if (pick < 84) begin
                    // long announced length, abandoned by the next start
                    len = int'($urandom_range(256, 65535));
                    send_packet(len, int'($urandom_range(0, 6)));
                    sent += 4;
                end else begin
                    send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                              1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
                    sent++;
                end
            end
            drain();
        end
        gaps_on = 1'b1;
    endtask

    // Long receiver hold-off while the sender keeps offering requests
    task automatic test_backpressure();
        set_config(8'hA5, 6'd4, 64'hD391_0000_0000_0000, 4'd2);
        ready_pct = 100;
        gaps_on   = 1'b0;
        hold_reqs++;
        send_packet(20, 19);
        send_packet(12, 11);
        drain();
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_reset_defaults();
        test_config_extremes();
        test_random_traffic();
        test_backpressure();
        if (mismatch_count == 0) begin
            $display("preamble_sync_length_framer_unit_tb OK");
        end else begin
            $display("preamble_sync_length_framer_unit_tb NOT OK");
        end
        $finish;
    end

    // Run limit
    initial begin
        #(RUN_LIMIT);
        $display("preamble_sync_length_framer_unit_tb NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/psf_pkg.sv
rtl/core/psf_skid.sv
rtl/core/psf_cfg_regs.sv
rtl/core/psf_emitter.sv
rtl/core/preamble_sync_length_framer_unit.sv
verif/preamble_sync_length_framer_unit_tb.sv
